/* src/isd_pkg.sv */
// ----------------------------------------------------------------------------
// isd_pkg : shared definitions for the interval set distance block
// Value width, table depth, request and status codes, helper functions.
// ----------------------------------------------------------------------------
package isd_pkg;

    // table depth and internal value width
    localparam int MAX_INTERVALS = 64;
    localparam int VALUE_BITS    = 32;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int ADDR_W        = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int FIELD_W       = 32;
    localparam logic [FIELD_W-1:0] SAT_MAX = '1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_VALUE = 2'd2;
    localparam logic [1:0] REQ_RANGE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_REVERSED = 2'd3;

    // table summary kept in flops next to the bound memory
    typedef struct packed {
        count_t count;
        value_t first_low;
        value_t last_high;
    } table_stat_t;

    // sign-extend a 32-bit field, wrap to VALUE_BITS, flip the sign bit so
    // unsigned compares follow signed order
    function automatic value_t to_biased(input logic [FIELD_W-1:0] f);
        logic [2*FIELD_W-1:0] e;
        value_t               v;
        e = {{FIELD_W{f[FIELD_W-1]}}, f};
        v = e[VALUE_BITS-1:0];
        v[VALUE_BITS-1] = ~v[VALUE_BITS-1];
        return v;
    endfunction

    // clamp a distance to the 32-bit result range
    function automatic logic [FIELD_W-1:0] sat32(input value_t x);
        logic [VALUE_BITS+FIELD_W-1:0] w;
        w = (VALUE_BITS + FIELD_W)'(x);
        if (w > (VALUE_BITS + FIELD_W)'(SAT_MAX))
            return SAT_MAX;
        else
            return w[FIELD_W-1:0];
    endfunction

endpackage

/* src/isd_table.sv */
// ----------------------------------------------------------------------------
// isd_table : interval bound storage
// One synchronous memory of {low, high} pairs with a registered read port,
// plus the entry count and the first low / last high kept in flops.
// ----------------------------------------------------------------------------
module isd_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                wr_en,
    input  isd_pkg::value_t     wr_lo,
    input  isd_pkg::value_t     wr_hi,
    input  isd_pkg::addr_t      rd_addr,
    output isd_pkg::value_t     rd_lo,
    output isd_pkg::value_t     rd_hi,
    output isd_pkg::table_stat_t stat
);
    import isd_pkg::*;

    logic [2*VALUE_BITS-1:0] mem [MAX_INTERVALS];
    logic [2*VALUE_BITS-1:0] rd_data_reg;
    count_t                  count_reg;
    value_t                  first_low_reg;
    value_t                  last_high_reg;
    addr_t                   wr_addr;

    assign wr_addr = count_reg[ADDR_W-1:0];

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_hi, wr_lo};
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_lo = rd_data_reg[VALUE_BITS-1:0];
    assign rd_hi = rd_data_reg[2*VALUE_BITS-1:VALUE_BITS];

    // count and end bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clr)
        begin
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_reg + count_t'(1);
        end
    end

    // end bounds are payload: only read when count is nonzero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (count_reg == '0)
                first_low_reg <= wr_lo;
            last_high_reg <= wr_hi;
        end
    end

    assign stat.count     = count_reg;
    assign stat.first_low = first_low_reg;
    assign stat.last_high = last_high_reg;

endmodule

/* src/interval_set_distance.sv */
// ----------------------------------------------------------------------------
// interval_set_distance : distance of values and ranges to an interval set
// Holds sorted disjoint intervals; answers value and range violation queries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: ivl lo/hi, value, range lo/hi; tuser: req
//  m_*       out  m_tvalid/m_tready  tdata: violation, min, max; tuser: status
//
//  Clear and load skip the walk. Queries walk the bound memory one entry a
//  cycle through its single read port. Reset empties the table at once, no
//  clearing pass. One item in flight; a new item is taken while a result
//  waits in the output register, and a stalled output holds the block in
//  its last step.
// ----------------------------------------------------------------------------
module interval_set_distance (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] interval_low, [63:32] interval_high, [95:64] query_value,
    // [127:96] range_low, [159:128] range_high
    input  logic [159:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] violation, [63:32] min_violation, [95:64] max_violation
    output logic [95:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser
);
    import isd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_DONE
    } state_t;

    state_t       state_reg;
    logic [1:0]   req_reg;
    logic [1:0]   stat_reg;
    value_t       a_reg, b_reg;
    addr_t        idx_reg;
    value_t       prev_hi_reg;
    logic         found_a_reg, found_b_reg;
    value_t       walk_a_reg, walk_b_reg;
    logic         overlap_reg;
    value_t       halfmax_reg;
    value_t       va_reg, vb_reg;
    logic         m_tvalid_reg;
    logic [95:0]  m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    // table interface
    logic         tbl_clr, tbl_wr;
    value_t       in_lo, in_hi, in_val, in_rlo, in_rhi;
    addr_t        rd_addr;
    value_t       rd_lo, rd_hi;
    table_stat_t  tstat;

    logic         in_accept;
    logic [1:0]   req_in;
    logic         load_bad;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign req_in    = s_tuser;

    assign in_lo  = to_biased(s_tdata[31:0]);
    assign in_hi  = to_biased(s_tdata[63:32]);
    assign in_val = to_biased(s_tdata[95:64]);
    assign in_rlo = to_biased(s_tdata[127:96]);
    assign in_rhi = to_biased(s_tdata[159:128]);

    // load check: full, reversed, or not above the last stored high
    assign load_bad = (tstat.count >= count_t'(MAX_INTERVALS)) || (in_lo > in_hi) ||
                      ((tstat.count != '0) && (in_lo <= tstat.last_high));

    assign tbl_clr = in_accept && (req_in == REQ_CLEAR);
    assign tbl_wr  = in_accept && (req_in == REQ_LOAD) && !load_bad;
    assign rd_addr = (state_reg == S_IDLE) ? '0 : idx_reg + addr_t'(1);

    isd_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (tbl_clr),
        .wr_en   (tbl_wr),
        .wr_lo   (in_lo),
        .wr_hi   (in_hi),
        .rd_addr (rd_addr),
        .rd_lo   (rd_lo),
        .rd_hi   (rd_hi),
        .stat    (tstat)
    );

    // per-entry walk logic
    value_t da1, da2, db1, db2, gap_a, gap_b, walk_a_next, walk_b_next;
    value_t half;
    logic [VALUE_BITS:0] peak_sum;
    value_t peak;
    logic   overlap_hit, peak_hit, last_entry;

    always_comb
    begin
        da1 = a_reg - prev_hi_reg;
        da2 = rd_lo - a_reg;
        db1 = b_reg - prev_hi_reg;
        db2 = rd_lo - b_reg;
        gap_a = (da1 < da2) ? da1 : da2;
        gap_b = (db1 < db2) ? db1 : db2;
        walk_a_next = (a_reg >= rd_lo) ? '0 : gap_a;
        walk_b_next = (b_reg >= rd_lo) ? '0 : gap_b;
        overlap_hit = (rd_lo <= b_reg) && (rd_hi >= a_reg);
        // gap midpoint between previous high and this low
        half     = (rd_lo - prev_hi_reg) >> 1;
        peak_sum = {1'b0, prev_hi_reg} + {1'b0, rd_lo};
        peak     = peak_sum[VALUE_BITS:1];
        peak_hit = (idx_reg != '0) && (peak >= a_reg) && (peak <= b_reg) &&
                   (half > halfmax_reg);
        last_entry = (count_t'(idx_reg) + count_t'(1)) == tstat.count;
    end

    // outside-the-set distances, applied after the walk
    value_t va_next, vb_next;

    always_comb
    begin
        if (a_reg < tstat.first_low)
            va_next = tstat.first_low - a_reg;
        else if (a_reg > tstat.last_high)
            va_next = a_reg - tstat.last_high;
        else
            va_next = walk_a_reg;
        if (b_reg < tstat.first_low)
            vb_next = tstat.first_low - b_reg;
        else if (b_reg > tstat.last_high)
            vb_next = b_reg - tstat.last_high;
        else
            vb_next = walk_b_reg;
    end

    // result assembly
    value_t       mx_ab, mx, mn;
    logic         ok;
    logic [95:0]  m_tdata_next;
    logic         out_free;

    always_comb
    begin
        mx_ab = (va_reg > vb_reg) ? va_reg : vb_reg;
        mx    = (halfmax_reg > mx_ab) ? halfmax_reg : mx_ab;
        mn    = overlap_reg ? '0 : ((va_reg < vb_reg) ? va_reg : vb_reg);
        ok    = (stat_reg == ST_OK);
        m_tdata_next = '0;
        if (ok && (req_reg == REQ_VALUE))
            m_tdata_next[31:0] = sat32(va_reg);
        if (ok && (req_reg == REQ_RANGE))
        begin
            m_tdata_next[63:32] = sat32(mn);
            m_tdata_next[95:64] = sat32(mx);
        end
        out_free = !m_tvalid_reg || m_tready;
    end

    // control sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        req_reg     <= req_in;
                        idx_reg     <= '0;
                        found_a_reg <= 1'b0;
                        found_b_reg <= 1'b0;
                        overlap_reg <= 1'b0;
                        halfmax_reg <= '0;
                        unique case (req_in)
                            REQ_CLEAR:
                            begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_DONE;
                            end
                            REQ_LOAD:
                            begin
                                stat_reg  <= load_bad ? ST_REJECTED : ST_OK;
                                state_reg <= S_DONE;
                            end
                            REQ_VALUE:
                            begin
                                a_reg <= in_val;
                                b_reg <= in_val;
                                if (tstat.count == '0)
                                begin
                                    stat_reg  <= ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    stat_reg  <= ST_OK;
                                    state_reg <= S_WALK;
                                end
                            end
                            default:
                            begin
                                a_reg <= in_rlo;
                                b_reg <= in_rhi;
                                if (in_rlo > in_rhi)
                                begin
                                    stat_reg  <= ST_REVERSED;
                                    state_reg <= S_DONE;
                                end
                                else if (tstat.count == '0)
                                begin
                                    stat_reg  <= ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    stat_reg  <= ST_OK;
                                    state_reg <= S_WALK;
                                end
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    // first entry whose high reaches the value holds it or its gap
                    if (!found_a_reg && (a_reg <= rd_hi))
                    begin
                        found_a_reg <= 1'b1;
                        walk_a_reg  <= walk_a_next;
                    end
                    if (!found_b_reg && (b_reg <= rd_hi))
                    begin
                        found_b_reg <= 1'b1;
                        walk_b_reg  <= walk_b_next;
                    end
                    if (overlap_hit)
                        overlap_reg <= 1'b1;
                    if (peak_hit)
                        halfmax_reg <= half;
                    prev_hi_reg <= rd_hi;
                    if (last_entry)
                        state_reg <= S_FIN;
                    else
                        idx_reg <= idx_reg + addr_t'(1);
                end
                S_FIN:
                begin
                    va_reg    <= va_next;
                    vb_reg    <= vb_next;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= m_tdata_next;
                        m_tuser_reg  <= stat_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tstat.count <= count_t'(MAX_INTERVALS))
        else $error("entry count above table depth");

    // walk index stays inside the stored entries
    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (count_t'(idx_reg) < tstat.count))
        else $error("walk index beyond entry count");

    // any error status carries all-zero values
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("nonzero values with error status");

    // a range result never has min above max
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:32] <= m_tdata[95:64]))
        else $error("min violation above max violation");

    // a walk ends right after its last entry
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WALK) && last_entry) |=> (state_reg == S_FIN))
        else $error("walk did not end after last entry");
`endif

endmodule

/* test/interval_set_distance_check.sv */
// ----------------------------------------------------------------------------
// interval_set_distance_check : result checker for interval_set_distance
// Watches both stream channels, keeps its own copy of the interval table,
// works out the answer to every accepted request and compares each returned
// result, field by field, with the oldest answer still due.
// ----------------------------------------------------------------------------
module interval_set_distance_check (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [31:0] interval_low, [63:32] interval_high, [95:64] query_value,
    // [127:96] range_low, [159:128] range_high
    input  logic [159:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] violation, [63:32] min_violation, [95:64] max_violation
    input  logic [95:0]  m_tdata,
    // [1:0] status
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           answers_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import isd_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef logic [63:0] wide_t;

    typedef struct packed {
        logic [31:0] viol;
        logic [31:0] vmin;
        logic [31:0] vmax;
        logic [1:0]  status;
    } answer_t;

    // table copy, bounds kept with the sign bit flipped so plain compares work
    wide_t   lo_tab [MAX_INTERVALS];
    wide_t   hi_tab [MAX_INTERVALS];
    int      stored     = 0;
    answer_t due_q [$];
    int      mismatches = 0;
    int      result_no  = 0;

    // sign-extend a field, wrap to the value width, flip the sign bit
    function automatic wide_t biased(input logic [31:0] f);
        wide_t e;
        e = {{32{f[31]}}, f} & ((64'd1 << VALUE_BITS) - 64'd1);
        e = e ^ (64'd1 << (VALUE_BITS - 1));
        return e;
    endfunction

    function automatic logic [31:0] clamp32(input wide_t x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // distance of one value to the stored set; table must not be empty
    function automatic wide_t distance_of(input wide_t v);
        wide_t up, dn;
        if (v < lo_tab[0])
            return lo_tab[0] - v;
        if (v > hi_tab[stored-1])
            return v - hi_tab[stored-1];
        for (int i = 0; i < stored; i++)
        begin
            if (v <= hi_tab[i])
            begin
                if (v >= lo_tab[i] || i == 0)
                    return '0;
                up = v - hi_tab[i-1];
                dn = lo_tab[i] - v;
                return (up < dn) ? up : dn;
            end
        end
        return '0;
    endfunction

    // apply one request to the table copy and return its answer
    task automatic answer_request(input logic [1:0] req, input logic [159:0] d,
                                  output answer_t r);
        wide_t a, b, va, vb, mn, mx, half, peak;
        r = '0;
        case (req)
            REQ_CLEAR:
            begin
                stored = 0;
            end
            REQ_LOAD:
            begin
                a = biased(d[31:0]);
                b = biased(d[63:32]);
                if (stored >= MAX_INTERVALS || a > b)
                    r.status = ST_REJECTED;
                else if (stored > 0 && a <= hi_tab[stored-1])
                    r.status = ST_REJECTED;
                else
                begin
                    lo_tab[stored] = a;
                    hi_tab[stored] = b;
                    stored++;
                end
            end
            REQ_VALUE:
            begin
                if (stored == 0)
                    r.status = ST_EMPTY;
                else
                    r.viol = clamp32(distance_of(biased(d[95:64])));
            end
            default:
            begin
                a = biased(d[127:96]);
                b = biased(d[159:128]);
                if (a > b)
                    r.status = ST_REVERSED;
                else if (stored == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    va = distance_of(a);
                    vb = distance_of(b);
                    mx = (va > vb) ? va : vb;
                    mn = (va < vb) ? va : vb;
                    for (int i = 0; i < stored; i++)
                    begin
                        // any overlap with the range brings the minimum to zero
                        if (lo_tab[i] <= b && hi_tab[i] >= a)
                            mn = '0;
                        // midpoint of a gap is its local maximum
                        if (i > 0)
                        begin
                            half = (lo_tab[i] - hi_tab[i-1]) >> 1;
                            peak = hi_tab[i-1] + half;
                            if (peak >= a && peak <= b && half > mx)
                                mx = half;
                        end
                    end
                    r.vmin = clamp32(mn);
                    r.vmax = clamp32(mx);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                      result_no, name, got, want));
    endtask

    // results first: a result never belongs to the item taken at the same edge
    always @(posedge clk)
    begin : watch
        answer_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
                if (due_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none due: %h",
                                              result_no, got));
                else
                begin
                    want = due_q.pop_front();
                    compare_field("violation", got.viol, want.viol);
                    compare_field("min_violation", got.vmin, want.vmin);
                    compare_field("max_violation", got.vmax, want.vmax);
                    compare_field("status", 32'(got.status), 32'(want.status));
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
            begin
                answer_request(s_tuser, s_tdata, want);
                due_q.push_back(want);
            end
        end
        fail_count  <= mismatches;
        answers_due <= due_q.size();
    end

endmodule

/* test/tb_interval_set_distance.sv */
// ----------------------------------------------------------------------------
// tb_interval_set_distance : testbench top for interval_set_distance
// Drives a directed sequence over the bound extremes, rejected loads, empty
// and reversed queries, then random table builds followed by value and range
// queries, with random idle bursts on both channels. Checking is done by
// interval_set_distance_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_interval_set_distance;
    timeunit 1ns;
    timeprecision 1ps;

    import isd_pkg::*;

    localparam int ITEMS = 1300;
    localparam int CALM  = 150;      // last items run with no idling
    localparam int LIMIT = 800000;
    localparam int VMIN  = 32'h8000_0000;
    localparam int VMAX  = 32'h7FFF_FFFF;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    int fail_count;
    int answers_due;
    int items_sent = 0;
    int cycles     = 0;
    int stall_left = 0;
    bit src_gaps   = 1'b0;
    bit sink_gaps  = 1'b0;

    // intervals meant to be in the table, used to aim queries
    int ivl_lo [$];
    int ivl_hi [$];

    interval_set_distance u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    interval_set_distance_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .answers_due (answers_due)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (sink_gaps && items_sent < ITEMS - CALM && $urandom_range(0, 9) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
            m_tready <= 1'b1;
    end

    // one item, with an optional idle burst ahead of it
    task automatic send(input logic [1:0] req, input int f0, input int f1,
                        input int f2, input int f3, input int f4);
        if (src_gaps && items_sent < ITEMS - CALM && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {f4, f3, f2, f1, f0};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wipe();
        send(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic load(input int lo, input int hi);
        send(REQ_LOAD, lo, hi, $urandom, $urandom, $urandom);
    endtask

    task automatic probe(input int v);
        send(REQ_VALUE, $urandom, $urandom, v, $urandom, $urandom);
    endtask

    task automatic sweep(input int a, input int b);
        send(REQ_RANGE, $urandom, $urandom, $urandom, a, b);
    endtask

    // value near a stored bound, inside an interval, mid-gap or anywhere
    function automatic int pick_value();
        int     sel, idx;
        longint mid;
        sel = $urandom_range(0, 9);
        if (ivl_lo.size() == 0 || sel == 0)
            return $urandom;
        if (sel == 1)
            return ($urandom_range(0, 1) != 0) ? VMIN : VMAX;
        idx = $urandom_range(0, ivl_lo.size() - 1);
        case (sel)
            2, 3: return ivl_lo[idx] - $urandom_range(0, 3);
            4, 5: return ivl_hi[idx] + $urandom_range(0, 3);
            6, 7:
            begin
                if (idx == 0)
                    return ivl_lo[idx];
                mid = (longint'(ivl_hi[idx-1]) + longint'(ivl_lo[idx])) >>> 1;
                return int'(mid + $urandom_range(0, 2) - 1);
            end
            default:
            begin
                mid = longint'(ivl_hi[idx]) - longint'(ivl_lo[idx]);
                return int'(longint'(ivl_lo[idx]) + longint'($urandom_range(0, mid)));
            end
        endcase
    endfunction

    initial
    begin
        int     kind, want, span, pick, a, b;
        longint cur, lo, hi;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, reversed range, rejected loads, extremes
        sweep(5, 4);                // reversed is reported before empty
        probe(VMIN);
        sweep(VMIN, VMAX);
        load(10, 9);                // low above high
        load(VMIN, VMIN);
        load(-100, -50);
        load(-60, 0);               // overlaps the last interval
        load(-50, -40);             // low equal to last high
        load(1000, 1001);
        load(VMAX, VMAX);
        load(VMAX, VMAX);           // not above the last interval
        probe(VMIN);
        probe(VMIN + 1);
        probe(-75);
        probe(500);
        probe(VMAX - 1);
        sweep(VMIN, VMAX);
        sweep(2, 999);
        wipe();
        load(0, 0);
        probe(VMIN);
        probe(VMAX);
        sweep(VMIN, VMAX);          // overhangs on both sides
        wipe();
        load(VMAX, VMAX);
        probe(VMIN);                // widest possible distance

        // random: build a table, then query it
        while (items_sent < ITEMS)
        begin
            src_gaps  = ($urandom_range(0, 2) != 0);
            sink_gaps <= ($urandom_range(0, 2) != 0);
            kind = $urandom_range(0, 9);

            if (kind == 0)
            begin
                // noise: any request, any fields
                repeat ($urandom_range(8, 20))
                    send($urandom_range(0, 3), $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            end
            else
            begin
                if (kind == 1)
                    want = $urandom_range(MAX_INTERVALS - 2, MAX_INTERVALS + 2);
                else if (kind == 2)
                    want = 0;
                else
                    want = $urandom_range(1, 10);

                ivl_lo.delete();
                ivl_hi.delete();
                wipe();
                case ($urandom_range(0, 3))
                    0:       cur = longint'(VMIN) - 1;
                    1:       cur = longint'(int'($urandom));
                    default: cur = longint'($urandom_range(0, 2000)) - 1000;
                endcase
                span = (want > 16) ? (1 << $urandom_range(0, 14))
                                   : (1 << $urandom_range(0, 28));

                for (int i = 0; i < want; i++)
                begin
                    // malformed load: reversed bounds or not above the last one
                    if (ivl_lo.size() != 0 && $urandom_range(0, 7) == 0)
                    begin
                        if ($urandom_range(0, 1) != 0)
                            load(int'(cur + 2), int'(cur + 1));
                        else
                            load(int'(cur - $urandom_range(0, 3)),
                                 int'(cur + $urandom_range(0, 9)));
                    end
                    lo = cur + 1 + longint'($urandom_range(0, span));
                    hi = lo + longint'($urandom_range(0, span));
                    if (lo > VMAX)
                        break;
                    if (hi > VMAX)
                        hi = VMAX;
                    load(int'(lo), int'(hi));
                    if (ivl_lo.size() < MAX_INTERVALS)
                    begin
                        ivl_lo.push_back(int'(lo));
                        ivl_hi.push_back(int'(hi));
                    end
                    cur = hi;
                end

                // sometimes run the set up to the top value
                if (want != 0 && cur < VMAX && $urandom_range(0, 4) == 0)
                begin
                    load(int'(cur + 1), VMAX);
                    if (ivl_lo.size() < MAX_INTERVALS)
                    begin
                        ivl_lo.push_back(int'(cur + 1));
                        ivl_hi.push_back(VMAX);
                    end
                end

                repeat ($urandom_range(4, 20))
                begin
                    pick = $urandom_range(0, 19);
                    a    = pick_value();
                    b    = pick_value();
                    if (pick < 9)
                        probe(a);
                    else if (pick < 18)
                    begin
                        if (pick == 17)
                            b = a;
                        if (a > b)
                            sweep(b, a);
                        else
                            sweep(a, b);
                    end
                    else
                    begin
                        // reversed range
                        if (a == b)
                        begin
                            a = VMAX;
                            b = VMIN;
                        end
                        if (a > b)
                            sweep(a, b);
                        else
                            sweep(b, a);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due != 0);
        repeat (MAX_INTERVALS + 16) @(posedge clk);

        if (fail_count == 0 && answers_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
